// ===== src/ltss_pkg.sv =====
`timescale 1ns / 1ps

package ltss_pkg;

  // Width of lengths, positions, counts and entry indexes.
  localparam int unsigned LenBits = 16;

  // Varint prefixes that announce 2 and 4 following bytes; larger ones mean 8.
  localparam logic [7:0] VarintPrefix2 = 8'hfd;
  localparam logic [7:0] VarintPrefix4 = 8'hfe;

  // Byte widths of the fixed little-endian fields.
  localparam int unsigned PrevoutBytes = 32;
  localparam int unsigned WordBytes    = 4;
  localparam int unsigned ValueBytes   = 8;

  // Section codes as they appear on the section output.
  localparam logic [3:0] SecVersion      = 4'd0;
  localparam logic [3:0] SecIncount      = 4'd1;
  localparam logic [3:0] SecPrevout      = 4'd2;
  localparam logic [3:0] SecVout         = 4'd3;
  localparam logic [3:0] SecInScriptLen  = 4'd4;
  localparam logic [3:0] SecInScript     = 4'd5;
  localparam logic [3:0] SecSequence     = 4'd6;
  localparam logic [3:0] SecOutcount     = 4'd7;
  localparam logic [3:0] SecValue        = 4'd8;
  localparam logic [3:0] SecOutScriptLen = 4'd9;
  localparam logic [3:0] SecOutScript    = 4'd10;
  localparam logic [3:0] SecLocktime     = 4'd11;
  localparam logic [3:0] SecTrailing     = 4'd12;
  localparam logic [3:0] SecError        = 4'd13;

  // Parse state, one-hot.
  typedef enum logic [13:0] {
    ST_VERSION    = 14'b00000000000001,
    ST_INCOUNT    = 14'b00000000000010,
    ST_PREVOUT    = 14'b00000000000100,
    ST_VOUT       = 14'b00000000001000,
    ST_INSLEN     = 14'b00000000010000,
    ST_INSCRIPT   = 14'b00000000100000,
    ST_SEQUENCE   = 14'b00000001000000,
    ST_OUTCOUNT   = 14'b00000010000000,
    ST_VALUE      = 14'b00000100000000,
    ST_OUTSLEN    = 14'b00001000000000,
    ST_OUTSCRIPT  = 14'b00010000000000,
    ST_LOCKTIME   = 14'b00100000000000,
    ST_TRAILING   = 14'b01000000000000,
    ST_ERROR      = 14'b10000000000000
  } parse_state_e;

  // One result item.
  typedef struct packed {
    logic [3:0]         section;
    logic [LenBits-1:0] entry_index;
    logic [LenBits-1:0] field_offset;
    logic               value_done;
    logic [63:0]        number;
    logic               input_event;
    logic               output_event;
    logic [63:0]        amount;
    logic [LenBits-1:0] script_length;
    logic               tx_done;
    logic [LenBits-1:0] consumed_length;
    logic               error;
  } result_t;

  function automatic logic [3:0] sec_code(parse_state_e st);
    logic [3:0] code;
    unique case (st)
      ST_VERSION:   code = SecVersion;
      ST_INCOUNT:   code = SecIncount;
      ST_PREVOUT:   code = SecPrevout;
      ST_VOUT:      code = SecVout;
      ST_INSLEN:    code = SecInScriptLen;
      ST_INSCRIPT:  code = SecInScript;
      ST_SEQUENCE:  code = SecSequence;
      ST_OUTCOUNT:  code = SecOutcount;
      ST_VALUE:     code = SecValue;
      ST_OUTSLEN:   code = SecOutScriptLen;
      ST_OUTSCRIPT: code = SecOutScript;
      ST_LOCKTIME:  code = SecLocktime;
      ST_TRAILING:  code = SecTrailing;
      default:      code = SecError;
    endcase
    return code;
  endfunction

endpackage

// ===== src/legacy_tx_stream_scanner_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: a byte taken at the input is held in the input stage register, and its
// result is registered in the result stage, where it waits until it is taken.
// Throughput: one byte per cycle while the result output is not stalled.
// Reset (rst_ni low, asynchronous) empties both pipeline stages and returns the
// parser to the start of a transaction, as if the next byte carried first.

module legacy_tx_stream_scanner_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic [ltss_pkg::LenBits-1:0] buffer_length_i,
  input  logic                         first_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   section_o,
  output logic [ltss_pkg::LenBits-1:0] entry_index_o,
  output logic [ltss_pkg::LenBits-1:0] field_offset_o,
  output logic                         value_done_o,
  output logic [63:0]                  number_o,
  output logic                         input_event_o,
  output logic                         output_event_o,
  output logic [63:0]                  amount_o,
  output logic [ltss_pkg::LenBits-1:0] script_length_o,
  output logic                         tx_done_o,
  output logic [ltss_pkg::LenBits-1:0] consumed_length_o,
  output logic                         error_o
);

  localparam int unsigned LB = ltss_pkg::LenBits;

  // Input stage: one registered byte waiting for the parse step.
  logic          in_valid_q;
  logic [7:0]    byte_q;
  logic [LB-1:0] len_q;
  logic          first_q;

  // Result stage.
  logic              out_valid_q;
  ltss_pkg::result_t res_q;
  ltss_pkg::result_t res;

  // Parse state registers and their next values.
  ltss_pkg::parse_state_e st_q, st_d, cur_st;
  logic [LB-1:0] fc_q, fc_d, cur_fc;
  logic [63:0]   acc_q, acc_d, cur_acc;
  logic [3:0]    vw_q, vw_d, cur_vw;
  logic [LB-1:0] el_q, el_d, cur_el;
  logic [LB-1:0] ce_q, ce_d, cur_ce;
  logic [LB-1:0] sbl_q, sbl_d, cur_sbl;
  logic [LB-1:0] pos_q, pos_d, cur_pos;
  logic [63:0]   held_q, held_d, cur_held;
  logic          failed_q, failed_d, cur_failed;
  logic          finished_q, finished_d, cur_finished;

  logic          adv;

  // Helper values of the parse step.
  logic [LB:0]   pos_inc;
  logic [LB:0]   fc_plus;
  logic [LB-1:0] fc_minus;
  logic [LB-1:0] left;
  logic          last_byte;
  logic [LB:0]   fix_width;
  logic          fix_last;
  logic [63:0]   fix_acc;
  logic [63:0]   var_acc;
  logic          var_done;
  logic [LB-1:0] var_fc;
  logic [3:0]    var_vw;
  logic          var_big;
  logic          var_nz;
  logic [LB-1:0] el_dec;
  logic [LB-1:0] fc_inc;
  logic [LB-1:0] sbl_dec;
  logic          done;
  logic          bad;

  // The pipeline moves when the input stage holds a byte and the result
  // register is empty or being emptied in this cycle. The parse state
  // advances together with it, so each byte updates the state exactly once.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      len_q   <= buffer_length_i;
      first_q <= first_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ltss_pkg::ST_VERSION;
      fc_q       <= '0;
      acc_q      <= '0;
      vw_q       <= '0;
      el_q       <= '0;
      ce_q       <= '0;
      sbl_q      <= '0;
      pos_q      <= '0;
      held_q     <= '0;
      failed_q   <= 1'b0;
      finished_q <= 1'b0;
    end else if (adv) begin
      st_q       <= st_d;
      fc_q       <= fc_d;
      acc_q      <= acc_d;
      vw_q       <= vw_d;
      el_q       <= el_d;
      ce_q       <= ce_d;
      sbl_q      <= sbl_d;
      pos_q      <= pos_d;
      held_q     <= held_d;
      failed_q   <= failed_d;
      finished_q <= finished_d;
    end
  end

  // A byte flagged first restarts the parse before it is classified, so the
  // step works on the reset values instead of the stored state.
  always_comb begin
    if (first_q) begin
      cur_st       = ltss_pkg::ST_VERSION;
      cur_fc       = '0;
      cur_acc      = '0;
      cur_vw       = '0;
      cur_el       = '0;
      cur_ce       = '0;
      cur_sbl      = '0;
      cur_pos      = '0;
      cur_held     = '0;
      cur_failed   = 1'b0;
      cur_finished = 1'b0;
    end else begin
      cur_st       = st_q;
      cur_fc       = fc_q;
      cur_acc      = acc_q;
      cur_vw       = vw_q;
      cur_el       = el_q;
      cur_ce       = ce_q;
      cur_sbl      = sbl_q;
      cur_pos      = pos_q;
      cur_held     = held_q;
      cur_failed   = failed_q;
      cur_finished = finished_q;
    end
  end

  // Shared pieces: buffer bookkeeping, the fixed-field shift-in and the
  // varint shift-in. The case below picks the one that fits the section.
  always_comb begin
    pos_inc   = {1'b0, cur_pos} + 1'b1;
    last_byte = pos_inc >= {1'b0, len_q};
    left      = (pos_inc <= {1'b0, len_q}) ? (len_q - pos_inc[LB-1:0]) : '0;
    fc_plus   = {1'b0, cur_fc} + 1'b1;
    fc_minus  = cur_fc - 1'b1;
    fc_inc    = fc_plus[LB-1:0];
    sbl_dec   = cur_sbl - 1'b1;
    el_dec    = cur_el - 1'b1;

    // Fixed little-endian field: byte n lands in lane n, only the first
    // eight lanes are kept.
    unique case (cur_st)
      ltss_pkg::ST_PREVOUT: fix_width = (LB+1)'(ltss_pkg::PrevoutBytes);
      ltss_pkg::ST_VALUE:   fix_width = (LB+1)'(ltss_pkg::ValueBytes);
      default:              fix_width = (LB+1)'(ltss_pkg::WordBytes);
    endcase
    fix_last = fc_plus >= fix_width;
    fix_acc  = (cur_fc == '0) ? '0 : cur_acc;
    if (cur_fc < LB'(8)) begin
      fix_acc[{cur_fc[2:0], 3'b000} +: 8] = byte_q;
    end

    // Varint: a small prefix is the value, a large one sets the byte count.
    var_acc = cur_acc;
    var_vw  = cur_vw;
    if (cur_fc == '0) begin
      if (byte_q < ltss_pkg::VarintPrefix2) begin
        var_acc  = {56'd0, byte_q};
        var_done = 1'b1;
        var_fc   = '0;
      end else begin
        var_acc  = '0;
        var_done = 1'b0;
        var_fc   = LB'(1);
        if (byte_q == ltss_pkg::VarintPrefix2) begin
          var_vw = 4'd2;
        end else if (byte_q == ltss_pkg::VarintPrefix4) begin
          var_vw = 4'd4;
        end else begin
          var_vw = 4'd8;
        end
      end
    end else begin
      if (cur_fc <= LB'(8)) begin
        var_acc[{fc_minus[2:0], 3'b000} +: 8] = byte_q;
      end
      var_done = cur_fc >= LB'(cur_vw);
      var_fc   = var_done ? '0 : fc_inc;
    end
    var_big = (|var_acc[63:LB]) || (var_acc[LB-1:0] > left);
    var_nz  = |var_acc;
  end

  // The parse step for one byte.
  always_comb begin
    st_d       = cur_st;
    fc_d       = cur_fc;
    acc_d      = cur_acc;
    vw_d       = cur_vw;
    el_d       = cur_el;
    ce_d       = cur_ce;
    sbl_d      = cur_sbl;
    held_d     = cur_held;
    failed_d   = cur_failed;
    finished_d = cur_finished;
    pos_d      = (&cur_pos) ? cur_pos : pos_inc[LB-1:0];
    res        = '0;
    done       = 1'b0;
    bad        = 1'b0;

    if (cur_finished) begin
      res.section = ltss_pkg::SecTrailing;
    end else if (cur_failed) begin
      res.section = ltss_pkg::SecError;
    end else begin
      res.section      = ltss_pkg::sec_code(cur_st);
      res.field_offset = cur_fc;
      if (cur_st == ltss_pkg::ST_PREVOUT || cur_st == ltss_pkg::ST_VOUT ||
          cur_st == ltss_pkg::ST_INSLEN || cur_st == ltss_pkg::ST_INSCRIPT ||
          cur_st == ltss_pkg::ST_SEQUENCE || cur_st == ltss_pkg::ST_VALUE ||
          cur_st == ltss_pkg::ST_OUTSLEN || cur_st == ltss_pkg::ST_OUTSCRIPT) begin
        res.entry_index = cur_ce;
      end

      unique case (cur_st) inside
        ltss_pkg::ST_VERSION, ltss_pkg::ST_PREVOUT, ltss_pkg::ST_VOUT,
        ltss_pkg::ST_SEQUENCE, ltss_pkg::ST_VALUE, ltss_pkg::ST_LOCKTIME: begin
          acc_d = fix_acc;
          fc_d  = fix_last ? '0 : fc_inc;
          if (fix_last) begin
            unique case (cur_st)
              ltss_pkg::ST_VERSION: begin
                done = 1'b1;
                st_d = ltss_pkg::ST_INCOUNT;
              end
              ltss_pkg::ST_PREVOUT: begin
                st_d = ltss_pkg::ST_VOUT;
              end
              ltss_pkg::ST_VOUT: begin
                done              = 1'b1;
                res.input_event   = 1'b1;
                st_d              = ltss_pkg::ST_INSLEN;
              end
              ltss_pkg::ST_SEQUENCE: begin
                done = 1'b1;
                el_d = el_dec;
                ce_d = cur_ce + 1'b1;
                st_d = (el_dec != '0) ? ltss_pkg::ST_PREVOUT : ltss_pkg::ST_OUTCOUNT;
              end
              ltss_pkg::ST_VALUE: begin
                done   = 1'b1;
                held_d = fix_acc;
                st_d   = ltss_pkg::ST_OUTSLEN;
              end
              default: begin
                // Last locktime byte: the transaction is complete.
                done                = 1'b1;
                finished_d          = 1'b1;
                res.tx_done         = 1'b1;
                res.consumed_length = pos_inc[LB-1:0];
                st_d                = ltss_pkg::ST_TRAILING;
              end
            endcase
          end
        end
        ltss_pkg::ST_INCOUNT, ltss_pkg::ST_OUTCOUNT: begin
          acc_d = var_acc;
          vw_d  = var_vw;
          fc_d  = var_fc;
          if (var_done) begin
            done = 1'b1;
            bad  = var_big;
            el_d = var_acc[LB-1:0];
            ce_d = '0;
            if (cur_st == ltss_pkg::ST_INCOUNT) begin
              st_d = var_nz ? ltss_pkg::ST_PREVOUT : ltss_pkg::ST_OUTCOUNT;
            end else begin
              st_d = var_nz ? ltss_pkg::ST_VALUE : ltss_pkg::ST_LOCKTIME;
            end
          end
        end
        ltss_pkg::ST_INSLEN, ltss_pkg::ST_OUTSLEN: begin
          acc_d = var_acc;
          vw_d  = var_vw;
          fc_d  = var_fc;
          if (var_done) begin
            done  = 1'b1;
            bad   = var_big;
            sbl_d = var_acc[LB-1:0];
            fc_d  = '0;
            if (cur_st == ltss_pkg::ST_INSLEN) begin
              st_d = var_nz ? ltss_pkg::ST_INSCRIPT : ltss_pkg::ST_SEQUENCE;
            end else if (var_nz) begin
              st_d = ltss_pkg::ST_OUTSCRIPT;
            end else begin
              // An empty output script ends the output on its length byte.
              res.output_event = 1'b1;
              res.amount       = cur_held;
              el_d             = el_dec;
              ce_d             = cur_ce + 1'b1;
              st_d = (el_dec != '0) ? ltss_pkg::ST_VALUE : ltss_pkg::ST_LOCKTIME;
            end
          end
        end
        ltss_pkg::ST_INSCRIPT, ltss_pkg::ST_OUTSCRIPT: begin
          fc_d  = fc_inc;
          sbl_d = sbl_dec;
          if (sbl_dec == '0) begin
            fc_d = '0;
            if (cur_st == ltss_pkg::ST_INSCRIPT) begin
              st_d = ltss_pkg::ST_SEQUENCE;
            end else begin
              res.output_event  = 1'b1;
              res.amount        = cur_held;
              res.script_length = fc_inc;
              el_d              = el_dec;
              ce_d              = cur_ce + 1'b1;
              st_d = (el_dec != '0) ? ltss_pkg::ST_VALUE : ltss_pkg::ST_LOCKTIME;
            end
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase

      res.value_done = done;
      res.number     = done ? acc_d : '0;

      // Truncation or an oversized count or script length ends the pass with an error,
      // unless this very byte finished the transaction.
      if (!finished_d && (bad || last_byte)) begin
        failed_d  = 1'b1;
        res.error = 1'b1;
        st_d      = ltss_pkg::ST_ERROR;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign section_o         = res_q.section;
  assign entry_index_o     = res_q.entry_index;
  assign field_offset_o    = res_q.field_offset;
  assign value_done_o      = res_q.value_done;
  assign number_o          = res_q.number;
  assign input_event_o     = res_q.input_event;
  assign output_event_o    = res_q.output_event;
  assign amount_o          = res_q.amount;
  assign script_length_o   = res_q.script_length;
  assign tx_done_o         = res_q.tx_done;
  assign consumed_length_o = res_q.consumed_length;
  assign error_o           = res_q.error;

endmodule

// ===== src/ltss_checker.sv =====
`timescale 1ns / 1ps

module ltss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [3:0]                   section_o,
  input logic                         value_done_o,
  input logic [63:0]                  number_o,
  input logic                         input_event_o,
  input logic                         output_event_o,
  input logic                         tx_done_o,
  input logic                         error_o
);

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(section_o) && $stable(number_o))
    else $error("result changed while stalled");

  // An input is reported only on the completing vout byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && input_event_o |-> value_done_o && section_o == ltss_pkg::SecVout)
    else $error("input event outside vout completion");

  // An output is reported only from its script length or script bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && output_event_o |->
      section_o == ltss_pkg::SecOutScriptLen || section_o == ltss_pkg::SecOutScript)
    else $error("output event in wrong section");

  // Completion comes on a locktime byte and never together with an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_done_o |-> !error_o && section_o == ltss_pkg::SecLocktime)
    else $error("bad transaction completion");

  // No number without a completed value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_done_o |-> number_o == 64'd0)
    else $error("number set without value_done");

endmodule

bind legacy_tx_stream_scanner_unit ltss_checker u_ltss_checker (.*);
